### hw/rtl/rational_arithmetic_unit_assert.svh
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTH
`define RAU_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) \
        else $error("assertion failed");
`else
`define RAU_ASSERT_IMPL(label, clk, rst_n, prop)
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/rau_pkg.sv
`default_nettype none
package rau_pkg;
    localparam int OPERAND_WIDTH = 16;
    localparam int MAG_WIDTH = 32;
    localparam int CNT_WIDTH = 6;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] FORM_ZERO   = 2'd0;
    localparam logic [1:0] FORM_WHOLE  = 2'd1;
    localparam logic [1:0] FORM_MIXED  = 2'd2;
    localparam logic [1:0] FORM_PROPER = 2'd3;

    localparam logic [1:0] DIV_NUM   = 2'd0;
    localparam logic [1:0] DIV_DEN   = 2'd1;
    localparam logic [1:0] DIV_WHOLE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_SUM,
        ST_GCD_START,
        ST_GCD,
        ST_DIVN_START,
        ST_DIVN,
        ST_DIVD_START,
        ST_DIVD,
        ST_WHOLE_START,
        ST_WHOLE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic mul;
        logic sum;
        logic gcd_start;
        logic gcd_step;
        logic div_start;
        logic [1:0] div_sel;
        logic div_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic error;
        logic gcd_done;
    } status_t;
endpackage
`default_nettype wire

### hw/rtl/rau_ctrl.sv
`default_nettype none
module rau_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire rau_pkg::status_t status,
    output rau_pkg::cmd_t         cmd
);
    import rau_pkg::*;

    state_t state_reg, state_next;
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        busy       = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
                state_next = status.error ? ST_DONE : ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum = 1'b1;
                state_next = ST_GCD_START;
            end
            ST_GCD_START:
            begin
                cmd.gcd_start = 1'b1;
                state_next = ST_GCD;
            end
            ST_GCD:
            begin
                if (status.gcd_done)
                    state_next = ST_DIVN_START;
                else
                    cmd.gcd_step = 1'b1;
            end
            ST_DIVN_START, ST_DIVD_START, ST_WHOLE_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel = (state_reg == ST_DIVN_START) ? DIV_NUM :
                              (state_reg == ST_DIVD_START) ? DIV_DEN : DIV_WHOLE;
                cnt_next = '0;
                state_next = (state_reg == ST_DIVN_START) ? ST_DIVN :
                             (state_reg == ST_DIVD_START) ? ST_DIVD : ST_WHOLE;
            end
            ST_DIVN, ST_DIVD, ST_WHOLE:
            begin
                cmd.div_step = 1'b1;
                cmd.div_sel = (state_reg == ST_DIVN) ? DIV_NUM :
                              (state_reg == ST_DIVD) ? DIV_DEN : DIV_WHOLE;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_WIDTH'(MAG_WIDTH))
                    state_next = (state_reg == ST_DIVN) ? ST_DIVD_START :
                                 (state_reg == ST_DIVD) ? ST_WHOLE_START : ST_DONE;
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

### hw/rtl/rau_datapath.sv
`default_nettype none
module rau_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire rau_pkg::cmd_t                     cmd,
    output rau_pkg::status_t                       status,
    input  wire logic [1:0]                        opcode,
    input  wire logic signed [15:0]                num_a,
    input  wire logic signed [15:0]                den_a,
    input  wire logic signed [15:0]                num_b,
    input  wire logic signed [15:0]                den_b,
    output logic                                   done,
    output logic                                   error_flag,
    output logic signed [32:0]                     result_numerator,
    output logic [30:0]                            result_denominator,
    output logic                                   negative_flag,
    output logic [31:0]                            whole_magnitude,
    output logic [29:0]                            remainder_numerator,
    output logic [1:0]                             form_code
);
    import rau_pkg::*;

    localparam int OW = OPERAND_WIDTH;
    localparam int MW = MAG_WIDTH;

    logic [1:0]    op_reg;
    logic [OW-1:0] na_reg, da_reg, nb_reg, db_reg;
    logic          sna_reg, sda_reg, snb_reg, sdb_reg;
    logic          err_reg;
    logic [MW-1:0] p1_reg, p2_reg, md_reg;
    logic          s1_reg, s2_reg, sd_reg;
    logic [MW:0]   mn_reg;
    logic          sn_reg;
    logic [MW:0]   gx_reg, gy_reg;
    logic [CNT_WIDTH-1:0] gk_reg;
    logic [MW:0]   q_reg, r_reg, dvd_reg, dvs_reg;
    logic [MW:0]   rn_reg;
    logic [MW-1:0] rd_reg;
    logic          done_reg;

    logic [OW-1:0] mag_na, mag_da, mag_nb, mag_db;
    logic [MW:0]   gx_next, gy_next;
    logic [CNT_WIDTH-1:0] gk_next;
    logic [MW:0]   gcd_val;
    logic [MW+1:0] rtrial;
    logic          sb;

    function automatic logic [OW-1:0] mag_of(input logic [OW-1:0] v);
        mag_of = v[OW-1] ? (~v + 1'b1) : v;
    endfunction

    assign mag_na = mag_of(na_reg);
    assign mag_da = mag_of(da_reg);
    assign mag_nb = mag_of(nb_reg);
    assign mag_db = mag_of(db_reg);

    // One binary gcd step: shared factors of two are counted in gk_reg, a lone
    // even value is halved, and of two odd values the larger is replaced by
    // half their difference.
    always_comb
    begin
        gx_next = gx_reg;
        gy_next = gy_reg;
        gk_next = gk_reg;
        unique case ({gx_reg[0], gy_reg[0]})
            2'b00:
            begin
                gx_next = gx_reg >> 1;
                gy_next = gy_reg >> 1;
                gk_next = gk_reg + 1'b1;
            end
            2'b01:
            begin
                gx_next = gx_reg >> 1;
            end
            2'b10:
            begin
                gy_next = gy_reg >> 1;
            end
            default:
            begin
                if (gx_reg >= gy_reg)
                    gx_next = (gx_reg - gy_reg) >> 1;
                else
                    gy_next = (gy_reg - gx_reg) >> 1;
            end
        endcase
    end

    assign gcd_val = (gx_reg | gy_reg) << gk_reg;
    assign rtrial = {r_reg, dvd_reg[MW]} - {1'b0, dvs_reg};
    assign sb = (op_reg == OP_SUB) ? ~snb_reg : snb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.finish;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            na_reg  <= num_a[OW-1:0];
            da_reg  <= den_a[OW-1:0];
            nb_reg  <= num_b[OW-1:0];
            db_reg  <= den_b[OW-1:0];
        end
        if (cmd.prep)
        begin
            err_reg <= (mag_da == '0) || (mag_db == '0) ||
                       ((op_reg == OP_DIV) && (mag_nb == '0));
            sna_reg <= na_reg[OW-1];
            sda_reg <= da_reg[OW-1];
            snb_reg <= nb_reg[OW-1];
            sdb_reg <= db_reg[OW-1];
        end
        if (cmd.mul)
        begin
            unique case (op_reg)
                OP_MUL:
                begin
                    p1_reg <= MW'(mag_na) * MW'(mag_nb);
                    s1_reg <= sna_reg ^ snb_reg;
                    md_reg <= MW'(mag_da) * MW'(mag_db);
                    sd_reg <= sda_reg ^ sdb_reg;
                end
                OP_DIV:
                begin
                    p1_reg <= MW'(mag_na) * MW'(mag_db);
                    s1_reg <= sna_reg ^ sdb_reg;
                    md_reg <= MW'(mag_da) * MW'(mag_nb);
                    sd_reg <= sda_reg ^ snb_reg;
                end
                default:
                begin
                    p1_reg <= MW'(mag_na) * MW'(mag_db);
                    s1_reg <= sna_reg ^ sdb_reg;
                    md_reg <= MW'(mag_da) * MW'(mag_db);
                    sd_reg <= sda_reg ^ sdb_reg;
                end
            endcase
            p2_reg <= MW'(mag_da) * MW'(mag_nb);
            s2_reg <= sda_reg ^ (sb & (mag_nb != '0));
        end
        if (cmd.sum)
        begin
            logic [MW:0] m;
            logic        s;
            m = '0;
            s = 1'b0;
            if (op_reg == OP_MUL || op_reg == OP_DIV)
            begin
                m = {1'b0, p1_reg};
                s = s1_reg;
            end
            else if (s1_reg == s2_reg)
            begin
                m = {1'b0, p1_reg} + {1'b0, p2_reg};
                s = s1_reg;
            end
            else if (p1_reg >= p2_reg)
            begin
                m = {1'b0, p1_reg - p2_reg};
                s = s1_reg;
            end
            else
            begin
                m = {1'b0, p2_reg - p1_reg};
                s = s2_reg;
            end
            mn_reg <= m;
            sn_reg <= (s ^ sd_reg) && (m != '0);
        end
        if (cmd.gcd_start)
        begin
            gx_reg <= mn_reg;
            gy_reg <= {1'b0, md_reg};
            gk_reg <= '0;
        end
        if (cmd.gcd_step)
        begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
            gk_reg <= gk_next;
        end
        if (cmd.div_start)
        begin
            q_reg <= '0;
            r_reg <= '0;
            unique case (cmd.div_sel)
                DIV_NUM:
                begin
                    dvd_reg <= mn_reg;
                    dvs_reg <= gcd_val;
                end
                DIV_DEN:
                begin
                    dvd_reg <= {1'b0, md_reg};
                    dvs_reg <= gcd_val;
                end
                default:
                begin
                    dvd_reg <= rn_reg;
                    dvs_reg <= q_reg;
                end
            endcase
        end
        if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[MW-1:0], 1'b0};
            if (!rtrial[MW+1])
            begin
                r_reg <= rtrial[MW:0];
                q_reg <= {q_reg[MW-1:0], 1'b1};
            end
            else
            begin
                r_reg <= {r_reg[MW-1:0], dvd_reg[MW]};
                q_reg <= {q_reg[MW-1:0], 1'b0};
            end
        end
        if (cmd.div_start && cmd.div_sel == DIV_DEN)
            rn_reg <= q_reg;
        if (cmd.div_start && cmd.div_sel == DIV_WHOLE)
            rd_reg <= q_reg[MW-1:0];
    end

    assign status.error    = (mag_da == '0) || (mag_db == '0) ||
                             ((op_reg == OP_DIV) && (mag_nb == '0));
    assign status.gcd_done = (gx_reg == '0) || (gy_reg == '0);

    always_comb
    begin
        done = done_reg;
        error_flag = err_reg;
        result_numerator = '0;
        result_denominator = '0;
        negative_flag = 1'b0;
        whole_magnitude = '0;
        remainder_numerator = '0;
        form_code = FORM_ZERO;
        if (!err_reg)
        begin
            result_numerator = sn_reg ? (33'd0 - rn_reg) : rn_reg;
            result_denominator = rd_reg[30:0];
            negative_flag = sn_reg;
            whole_magnitude = q_reg[MW-1:0];
            remainder_numerator = r_reg[29:0];
            if (rn_reg == '0)
                form_code = FORM_ZERO;
            else if (rd_reg == MW'(1))
                form_code = FORM_WHOLE;
            else if (rn_reg > {1'b0, rd_reg})
                form_code = FORM_MIXED;
            else
                form_code = FORM_PROPER;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/rational_arithmetic_unit.sv
// Rational arithmetic unit: adds, subtracts, multiplies or divides two
// signed fractions and returns the result in lowest terms.
// A request is taken at a rising edge where start is high and busy is low;
// busy then stays high until the result has been presented.
// The result appears on the result ports for exactly one cycle, marked by
// done; the receiver cannot hold it off, so it must capture it then.
// A request passes through the prep, multiply and sum steps, the binary gcd
// loop, whose number of steps depends on the operands, and three passes of a
// shared 33-step restoring divider (numerator, denominator, whole part);
// a request with an error goes from the prep step straight to the done state.
// One request is processed at a time; busy falls while done is high, so the
// next request can be taken at the edge that captures the result.
// A zero denominator, or division by a zero fraction, sets error_flag with
// every other field zero.
// Reset returns the controller to idle and drops any request in progress.
`default_nettype none
module rational_arithmetic_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         opcode,
    input  wire logic signed [15:0] num_a,
    input  wire logic signed [15:0] den_a,
    input  wire logic signed [15:0] num_b,
    input  wire logic signed [15:0] den_b,
    output logic                    done,
    output logic                    error_flag,
    output logic signed [32:0]      result_numerator,
    output logic [30:0]             result_denominator,
    output logic                    negative_flag,
    output logic [31:0]             whole_magnitude,
    output logic [29:0]             remainder_numerator,
    output logic [1:0]              form_code
);
    import rau_pkg::*;
`include "rational_arithmetic_unit_assert.svh"

    cmd_t    cmd;
    status_t status;

    rau_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    rau_datapath u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .opcode              (opcode),
        .num_a               (num_a),
        .den_a               (den_a),
        .num_b               (num_b),
        .den_b               (den_b),
        .done                (done),
        .error_flag          (error_flag),
        .result_numerator    (result_numerator),
        .result_denominator  (result_denominator),
        .negative_flag       (negative_flag),
        .whole_magnitude     (whole_magnitude),
        .remainder_numerator (remainder_numerator),
        .form_code           (form_code)
    );

    `RAU_ASSERT_NEXT(a_done_one_cycle, clk, rst_n, done, !done)
    `RAU_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `RAU_ASSERT_IMPL(a_err_zero, clk, rst_n, (done && error_flag) |-> (form_code == FORM_ZERO))
endmodule
`default_nettype wire
